/* rtl/glr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package glr_pkg;

  localparam int FRAC_BITS = 12;
  localparam int QW        = 30;
  localparam int QSH       = QW - FRAC_BITS;

  localparam logic FUNC_STEP = 1'b0;
  localparam logic FUNC_LOAD = 1'b1;

  localparam logic signed [15:0] DECAY_LOG_INIT = 16'(-3 * (1 << FRAC_BITS));
  localparam logic [30:0]        ONE_Q30        = 31'h4000_0000;
  localparam logic signed [63:0] HALF_Q30       = 64'sh0000_0000_2000_0000;
  localparam logic signed [32:0] LN2_Q30        = 33'sd744261118;
  localparam logic signed [32:0] RECIP_LN2      = 33'sd94548;
  localparam int                 K_EST_SH       = 26;
  localparam logic signed [39:0] GATE_CLAMP     = 40'sd53687091200;
  localparam logic signed [39:0] LAMBDA_ZERO_AT = 40'sd4294967296;
  localparam logic [63:0]        SIG_NUM        = 64'h1000_0000_0000_0000;
  localparam int                 TAYLOR_TERMS   = 12;
  localparam logic [12:0]        DECAY_MAX      = 13'd8191;

  typedef logic [4:0] op_t;

  localparam op_t OP_NOP    = 5'd0;
  localparam op_t OP_CLR    = 5'd1;
  localparam op_t OP_ACCEPT = 5'd2;
  localparam op_t OP_RD     = 5'd3;
  localparam op_t OP_EK     = 5'd4;
  localparam op_t OP_EK2    = 5'd5;
  localparam op_t OP_EL     = 5'd6;
  localparam op_t OP_ER     = 5'd7;
  localparam op_t OP_TM     = 5'd8;
  localparam op_t OP_TD     = 5'd9;
  localparam op_t OP_TW     = 5'd10;
  localparam op_t OP_ES     = 5'd11;
  localparam op_t OP_SIG    = 5'd12;
  localparam op_t OP_GSET   = 5'd13;
  localparam op_t OP_Z3     = 5'd14;
  localparam op_t OP_LAM    = 5'd15;
  localparam op_t OP_LAM0   = 5'd16;
  localparam op_t OP_L2     = 5'd17;
  localparam op_t OP_SQ     = 5'd18;
  localparam op_t OP_SQW    = 5'd19;
  localparam op_t OP_GS     = 5'd20;
  localparam op_t OP_A1     = 5'd21;
  localparam op_t OP_A2     = 5'd22;
  localparam op_t OP_OUT    = 5'd23;

  typedef struct packed {
    logic               func;
    logic [5:0]         channel;
    logic               seq_start;
    logic signed [15:0] x_in;
    logic signed [15:0] gate_pre;
    logic signed [15:0] decay_log_in;
  } glr_in_t;

  typedef struct packed {
    logic [5:0]         out_channel;
    logic signed [15:0] hidden;
    logic [12:0]        decay_factor;
  } glr_out_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic iter_busy;
    logic term_last;
    logic lam_zero;
    logic clr_last;
    logic in_load;
    logic in_oor;
  } dp_stat_t;

  typedef struct packed {
    logic start_div;
    logic start_sqrt;
    logic wide;
  } iter_cmd_t;

endpackage

`default_nettype wire

/* rtl/glr_iter.sv */
`timescale 1ns / 1ps
`default_nettype none

module glr_iter import glr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  iter_cmd_t   cmd,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic        busy,
  output logic [63:0] res
);

  localparam logic [6:0] WIDE_STEPS   = 7'd64;
  localparam logic [6:0] NARROW_STEPS = 7'd32;
  localparam logic [6:0] SQRT_STEPS   = 7'd32;
  localparam logic [63:0] SQRT_BIT0   = 64'h4000_0000_0000_0000;

  logic        busy_r;
  logic [6:0]  cnt_r;
  logic        sqrt_r;
  logic [63:0] a_r, q_r, d_r;
  logic [63:0] a_nxt, q_nxt, d_nxt;
  logic [64:0] t;
  logic [64:0] t_sub;
  logic        ge_div;
  logic [63:0] sq_s;
  logic        ge_sq;

  assign t      = {a_r, q_r[63]};
  assign t_sub  = t - {1'b0, d_r};
  assign ge_div = t >= {1'b0, d_r};
  assign sq_s   = q_r + d_r;
  assign ge_sq  = a_r >= sq_s;

  always_comb begin
    if (sqrt_r) begin
      a_nxt = ge_sq ? (a_r - sq_s) : a_r;
      q_nxt = ge_sq ? ((q_r >> 1) + d_r) : (q_r >> 1);
      d_nxt = d_r >> 2;
    end else begin
      a_nxt = ge_div ? t_sub[63:0] : t[63:0];
      q_nxt = {q_r[62:0], ge_div};
      d_nxt = d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (cmd.start_div) begin
      busy_r <= 1'b1;
      cnt_r  <= cmd.wide ? WIDE_STEPS : NARROW_STEPS;
    end else if (cmd.start_sqrt) begin
      busy_r <= 1'b1;
      cnt_r  <= SQRT_STEPS;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_div) begin
      sqrt_r <= 1'b0;
      a_r    <= '0;
      q_r    <= cmd.wide ? num : {num[31:0], 32'd0};
      d_r    <= den;
    end else if (cmd.start_sqrt) begin
      sqrt_r <= 1'b1;
      a_r    <= num;
      q_r    <= '0;
      d_r    <= SQRT_BIT0;
    end else if (busy_r) begin
      a_r <= a_nxt;
      q_r <= q_nxt;
      d_r <= d_nxt;
    end
  end

  assign busy = busy_r;
  assign res  = q_r;

endmodule

`default_nettype wire

/* rtl/glr_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module glr_dp import glr_pkg::*; #(
  parameter int CHANNELS = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  glr_in_t  in_data,
  input  dp_cmd_t  cmd,
  output dp_stat_t stat,
  output glr_out_t out_data
);

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic signed [15:0] hid_mem  [CHANNELS];
  logic signed [15:0] alog_mem [CHANNELS];
  logic signed [15:0] hid_q_r, alog_q_r;

  glr_in_t            item_r;
  logic [AW-1:0]      clr_cnt_r;
  logic signed [15:0] hprev_r;
  logic signed [39:0] z_r;
  logic signed [7:0]  k_r;
  logic [29:0]        r_r;
  logic [30:0]        term_r;
  logic [31:0]        sum_r;
  logic [3:0]         idx_r;
  logic [63:0]        exp_r;
  logic [30:0]        g_r, lam_r, gs_r;
  logic signed [63:0] prod_r, acc_r;
  logic signed [15:0] hnew_r;
  glr_out_t           out_r;

  logic               in_oor, in_load;
  logic [AW-1:0]      rd_a;
  logic               rd_en;
  logic               hid_we, alog_we;
  logic [AW-1:0]      hid_wa, alog_wa;
  logic signed [15:0] hid_wd, alog_wd;

  logic signed [32:0] ma, mb;
  logic signed [65:0] mp;
  logic               mult_en;

  iter_cmd_t          icmd;
  logic [63:0]        inum, iden, ires;
  logic               ibusy;

  logic [31:0]        recip;
  logic [5:0]         rsh;
  logic [63:0]        tq;

  logic signed [19:0] zs;
  logic signed [39:0] gi30, alog30, gid, s30;
  logic signed [40:0] r0, r_lo, r_hi;
  logic [63:0]        sum64, exp_val;
  logic [7:0]         nk;
  logic signed [63:0] acc_sum, hq;
  logic signed [15:0] hsat;
  logic [31:0]        lam_rnd, dqw;
  logic [12:0]        dq;
  logic [30:0]        one_m;

  assign in_oor  = int'(in_data.channel) >= CHANNELS;
  assign in_load = in_data.func == FUNC_LOAD;
  assign rd_a    = AW'(in_data.channel);
  assign rd_en   = (cmd.op == OP_ACCEPT) && !in_oor;

  assign hid_we  = (cmd.op == OP_CLR) || (cmd.op == OP_OUT);
  assign hid_wa  = (cmd.op == OP_CLR) ? clr_cnt_r : AW'(item_r.channel);
  assign hid_wd  = (cmd.op == OP_CLR) ? 16'sd0 : hnew_r;
  assign alog_we = (cmd.op == OP_CLR) || ((cmd.op == OP_ACCEPT) && in_load && !in_oor);
  assign alog_wa = (cmd.op == OP_CLR) ? clr_cnt_r : rd_a;
  assign alog_wd = (cmd.op == OP_CLR) ? DECAY_LOG_INIT : in_data.decay_log_in;

  always_ff @(posedge clk) begin
    if (hid_we) begin
      hid_mem[hid_wa] <= hid_wd;
    end
    if (rd_en) begin
      hid_q_r <= hid_mem[rd_a];
    end
  end

  always_ff @(posedge clk) begin
    if (alog_we) begin
      alog_mem[alog_wa] <= alog_wd;
    end
    if (rd_en) begin
      alog_q_r <= alog_mem[rd_a];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.op == OP_CLR) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  // divide the Taylor term by its index: multiply by the rounded-up reciprocal, then shift
  always_comb begin
    unique case (idx_r)
      4'd1: begin
        recip = 32'd2147483648;
        rsh   = 6'd31;
      end
      4'd2: begin
        recip = 32'd2147483648;
        rsh   = 6'd32;
      end
      4'd3: begin
        recip = 32'd2863311531;
        rsh   = 6'd33;
      end
      4'd4: begin
        recip = 32'd2147483648;
        rsh   = 6'd33;
      end
      4'd5: begin
        recip = 32'd3435973837;
        rsh   = 6'd34;
      end
      4'd6: begin
        recip = 32'd2863311531;
        rsh   = 6'd34;
      end
      4'd7: begin
        recip = 32'd2454267027;
        rsh   = 6'd34;
      end
      4'd8: begin
        recip = 32'd2147483648;
        rsh   = 6'd34;
      end
      4'd9: begin
        recip = 32'd3817748708;
        rsh   = 6'd35;
      end
      4'd10: begin
        recip = 32'd3435973837;
        rsh   = 6'd35;
      end
      4'd11: begin
        recip = 32'd3123612579;
        rsh   = 6'd35;
      end
      4'd12: begin
        recip = 32'd2863311531;
        rsh   = 6'd35;
      end
      default: begin
        recip = '0;
        rsh   = '0;
      end
    endcase
  end

  assign tq = $unsigned(prod_r) >> rsh;

  // shared multiplier
  always_comb begin
    unique case (cmd.op)
      OP_EK: begin
        ma = 33'(zs);
        mb = RECIP_LN2;
      end
      OP_EL: begin
        ma = 33'(k_r);
        mb = LN2_Q30;
      end
      OP_TM: begin
        ma = {2'b00, term_r};
        mb = {3'b000, r_r};
      end
      OP_TD: begin
        ma = {1'b0, prod_r[61:30]};
        mb = {1'b0, recip};
      end
      OP_L2: begin
        ma = {2'b00, lam_r};
        mb = {2'b00, lam_r};
      end
      OP_SQW: begin
        ma = {2'b00, g_r};
        mb = {2'b00, ires[30:0]};
      end
      OP_GS: begin
        ma = {2'b00, lam_r};
        mb = 33'(hprev_r);
      end
      OP_A1: begin
        ma = {2'b00, gs_r};
        mb = 33'(item_r.x_in);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign mp      = ma * mb;
  assign mult_en = (cmd.op == OP_EK) || (cmd.op == OP_EL) || (cmd.op == OP_TM) ||
                   (cmd.op == OP_TD) || (cmd.op == OP_L2) || (cmd.op == OP_SQW) ||
                   (cmd.op == OP_GS) || (cmd.op == OP_A1);

  // iterative divide / square root unit
  assign one_m = ONE_Q30 - prod_r[60:30];

  always_comb begin
    icmd.start_div  = cmd.op == OP_SIG;
    icmd.start_sqrt = cmd.op == OP_SQ;
    icmd.wide       = cmd.op == OP_SIG;
    unique case (cmd.op)
      OP_SIG: begin
        inum = SIG_NUM;
        iden = {33'd0, ONE_Q30} + exp_r;
      end
      OP_SQ: begin
        inum = {3'd0, one_m, 30'd0};
        iden = '0;
      end
      default: begin
        inum = '0;
        iden = '0;
      end
    endcase
  end

  glr_iter u_iter (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (icmd),
    .num   (inum),
    .den   (iden),
    .busy  (ibusy),
    .res   (ires)
  );

  // argument and range reduction
  assign zs     = z_r[39:20];
  assign gi30   = 40'(item_r.gate_pre) <<< QSH;
  assign alog30 = 40'(alog_q_r) <<< QSH;
  assign gid    = (gi30 > GATE_CLAMP) ? GATE_CLAMP : gi30;
  assign s30    = alog30 + gid;
  assign r0     = 41'(z_r) - 41'(prod_r);
  assign r_lo   = r0 + 41'(LN2_Q30);
  assign r_hi   = r0 - 41'(LN2_Q30);

  assign sum64   = {32'd0, sum_r};
  assign nk      = 8'(-k_r);
  assign exp_val = !k_r[7] ? (sum64 << k_r[5:0]) :
                   ((nk > 8'd63) ? 64'd0 : (sum64 >> nk[5:0]));

  assign acc_sum = acc_r + prod_r + HALF_Q30;
  assign hq      = acc_sum >>> QW;

  always_comb begin
    if (hq > 64'sd32767) begin
      hsat = 16'sh7fff;
    end else if (hq < -64'sd32768) begin
      hsat = 16'sh8000;
    end else begin
      hsat = hq[15:0];
    end
  end

  assign lam_rnd = {1'b0, lam_r} + (32'd1 << (QSH - 1));
  assign dqw     = lam_rnd >> QSH;
  assign dq      = (dqw > 32'(DECAY_MAX)) ? DECAY_MAX : dqw[12:0];

  always_ff @(posedge clk) begin
    if (mult_en) begin
      prod_r <= mp[63:0];
    end
    unique case (cmd.op)
      OP_ACCEPT: begin
        item_r <= in_data;
      end
      OP_RD: begin
        hprev_r <= item_r.seq_start ? 16'sd0 : hid_q_r;
        z_r     <= -gi30;
      end
      OP_EK2: begin
        k_r <= prod_r[K_EST_SH+7:K_EST_SH];
      end
      OP_ER: begin
        if (r0 < 41'sd0) begin
          k_r <= k_r - 8'sd1;
          r_r <= r_lo[29:0];
        end else if (r0 >= 41'(LN2_Q30)) begin
          k_r <= k_r + 8'sd1;
          r_r <= r_hi[29:0];
        end else begin
          r_r <= r0[29:0];
        end
        sum_r  <= {1'b0, ONE_Q30};
        term_r <= ONE_Q30;
        idx_r  <= 4'd1;
      end
      OP_TW: begin
        term_r <= tq[30:0];
        sum_r  <= sum_r + {1'b0, tq[30:0]};
        idx_r  <= idx_r + 4'd1;
      end
      OP_ES: begin
        exp_r <= exp_val;
      end
      OP_GSET: begin
        g_r <= ires[30:0];
        z_r <= s30;
      end
      OP_Z3: begin
        z_r <= -$signed(exp_r[39:0]);
      end
      OP_LAM: begin
        lam_r <= (exp_r > {33'd0, ONE_Q30}) ? ONE_Q30 : exp_r[30:0];
      end
      OP_LAM0: begin
        lam_r <= '0;
      end
      OP_GS: begin
        gs_r <= prod_r[60:30];
      end
      OP_A1: begin
        acc_r <= prod_r;
      end
      OP_A2: begin
        hnew_r <= hsat;
      end
      OP_OUT: begin
        out_r.out_channel  <= item_r.channel;
        out_r.hidden       <= hnew_r;
        out_r.decay_factor <= dq;
      end
      default: begin
      end
    endcase
  end

  assign stat.iter_busy = ibusy;
  assign stat.term_last = idx_r == 4'(TAYLOR_TERMS);
  assign stat.lam_zero  = s30 >= LAMBDA_ZERO_AT;
  assign stat.clr_last  = clr_cnt_r == AW'(CHANNELS - 1);
  assign stat.in_load   = in_load;
  assign stat.in_oor    = in_oor;

  assign out_data = out_r;

endmodule

`default_nettype wire

/* rtl/glr_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module glr_ctrl import glr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [4:0] S_CLEAR = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_RD    = 5'd2;
  localparam logic [4:0] S_EK    = 5'd3;
  localparam logic [4:0] S_EK2   = 5'd4;
  localparam logic [4:0] S_EL    = 5'd5;
  localparam logic [4:0] S_ER    = 5'd6;
  localparam logic [4:0] S_TM    = 5'd7;
  localparam logic [4:0] S_TD    = 5'd8;
  localparam logic [4:0] S_TW    = 5'd9;
  localparam logic [4:0] S_ES    = 5'd10;
  localparam logic [4:0] S_SIG   = 5'd11;
  localparam logic [4:0] S_SIGW  = 5'd12;
  localparam logic [4:0] S_Z3    = 5'd13;
  localparam logic [4:0] S_LAM   = 5'd14;
  localparam logic [4:0] S_LAM0  = 5'd15;
  localparam logic [4:0] S_L2    = 5'd16;
  localparam logic [4:0] S_SQ    = 5'd17;
  localparam logic [4:0] S_SQW   = 5'd18;
  localparam logic [4:0] S_GS    = 5'd19;
  localparam logic [4:0] S_A1    = 5'd20;
  localparam logic [4:0] S_A2    = 5'd21;
  localparam logic [4:0] S_OUT   = 5'd22;

  localparam logic [1:0] PH_GATE  = 2'd0;
  localparam logic [1:0] PH_INNER = 2'd1;
  localparam logic [1:0] PH_OUTER = 2'd2;

  logic [4:0] state_r, state_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = OP_NOP;
    unique case (state_r)
      S_CLEAR: begin
        cmd.op = OP_CLR;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_ACCEPT;
          if (!stat.in_oor && !stat.in_load) begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        cmd.op    = OP_RD;
        phase_nxt = PH_GATE;
        state_nxt = S_EK;
      end
      S_EK: begin
        cmd.op    = OP_EK;
        state_nxt = S_EK2;
      end
      S_EK2: begin
        cmd.op    = OP_EK2;
        state_nxt = S_EL;
      end
      S_EL: begin
        cmd.op    = OP_EL;
        state_nxt = S_ER;
      end
      S_ER: begin
        cmd.op    = OP_ER;
        state_nxt = S_TM;
      end
      S_TM: begin
        cmd.op    = OP_TM;
        state_nxt = S_TD;
      end
      S_TD: begin
        cmd.op    = OP_TD;
        state_nxt = S_TW;
      end
      S_TW: begin
        cmd.op    = OP_TW;
        state_nxt = stat.term_last ? S_ES : S_TM;
      end
      S_ES: begin
        cmd.op = OP_ES;
        if (phase_r == PH_GATE) begin
          state_nxt = S_SIG;
        end else if (phase_r == PH_INNER) begin
          state_nxt = S_Z3;
        end else begin
          state_nxt = S_LAM;
        end
      end
      S_SIG: begin
        cmd.op    = OP_SIG;
        state_nxt = S_SIGW;
      end
      S_SIGW: begin
        if (!stat.iter_busy) begin
          cmd.op = OP_GSET;
          if (stat.lam_zero) begin
            state_nxt = S_LAM0;
          end else begin
            phase_nxt = PH_INNER;
            state_nxt = S_EK;
          end
        end
      end
      S_Z3: begin
        cmd.op    = OP_Z3;
        phase_nxt = PH_OUTER;
        state_nxt = S_EK;
      end
      S_LAM: begin
        cmd.op    = OP_LAM;
        state_nxt = S_L2;
      end
      S_LAM0: begin
        cmd.op    = OP_LAM0;
        state_nxt = S_L2;
      end
      S_L2: begin
        cmd.op    = OP_L2;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        cmd.op    = OP_SQ;
        state_nxt = S_SQW;
      end
      S_SQW: begin
        if (!stat.iter_busy) begin
          cmd.op    = OP_SQW;
          state_nxt = S_GS;
        end
      end
      S_GS: begin
        cmd.op    = OP_GS;
        state_nxt = S_A1;
      end
      S_A1: begin
        cmd.op    = OP_A1;
        state_nxt = S_A2;
      end
      S_A2: begin
        cmd.op    = OP_A2;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = OP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      phase_r     <= PH_GATE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/gated_linear_recurrence_step_core.sv */
// Gated linear recurrence, one time step per word, signed Q3.12.
// in_data (valid/ready): func = 0 is a step word for one channel (x_in, gate_pre,
// seq_start), func = 1 loads the channel's log-decay. Load words and words whose
// channel is at or above CHANNELS give no result.
// out_data (valid/ready): one word per step word with the channel, the new
// saturated hidden value and the decay in unsigned Q1.12.
// A step word runs three exponentials (one when the decay is forced to zero),
// each 12 Taylor terms with the division by the term index done as a multiply
// by its reciprocal, a 64-step sigmoid division and a 32-step square root in
// the shared bit-serial unit. One word is in work at a time; the next step
// word is taken only once the previous one has reached the output register.
// After reset a clearing pass over all CHANNELS entries sets every hidden value
// to zero and every log-decay to -3.0; in_ready stays low meanwhile.
// While the receiver stalls the result holds in out_data, and the block takes
// and works one more word, which then waits for the output register.
`timescale 1ns / 1ps
`default_nettype none

module gated_linear_recurrence_step_core import glr_pkg::*; #(
  parameter int CHANNELS = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  glr_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output glr_out_t out_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  glr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  glr_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

`ifndef ASSERT_OFF
  a_iter_idle_at_start: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_SIG || cmd.op == OP_SQ) |-> !stat.iter_busy)
    else $error("divide/sqrt unit started while busy");

  a_ready_iter_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !stat.iter_busy)
    else $error("input ready while divide/sqrt unit busy");

  a_out_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_OUT) |-> (!out_valid || out_ready))
    else $error("result written over a word not yet taken");

  a_out_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_OUT) |=> out_valid)
    else $error("result written but out_valid low");
`endif

endmodule

`default_nettype wire
